[design/mbss_pkg.sv]
// ----------------------------------------------------------------------------
// mbss_pkg: shared types and constants of the masked byte signature scanner
// Signature geometry, status and register codes, queue sizing, and the
// structs that pass between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mbss_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int LEN_W             = 5;
	localparam int MASK_W            = 16;
	localparam int PAT_W             = 128;
	localparam int WIN_IDX_W         = $clog2(MAX_PATTERN_BYTES);
	localparam int CNT_W             = 32;
	localparam logic [CNT_W-1:0] SAT_MAX = '1;

	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_AMBIGUOUS = 2'd2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MASK   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd3;
	localparam int CFG_DATA_W = 64;

	// queue depth must be a power of two: pointers wrap on their own
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam int OUT_DATA_W = 72;

	typedef struct packed {
		logic [PAT_W-1:0]  pattern;
		logic [MASK_W-1:0] mask;
		logic [LEN_W-1:0]  length;
	} mbss_cfg_t;

	// one classified haystack byte
	typedef struct packed {
		logic             hit;
		logic             last;
		logic [CNT_W-1:0] offset;
	} mbss_entry_t;

endpackage

`default_nettype wire

[design/mbss_front.sv]
// ----------------------------------------------------------------------------
// mbss_front: byte window and masked compare
// Shifts each accepted byte into the window, tests the signature ending at
// the newest byte and hands a hit flag, start offset and last mark onward.
// ----------------------------------------------------------------------------
`default_nettype none

module mbss_front
	import mbss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mbss_cfg_t   cfg,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_last,
	output      logic        push,
	output      mbss_entry_t push_entry,
	input  wire logic        q_full
);

	logic [7:0]       window_q [MAX_PATTERN_BYTES];
	logic [CNT_W-1:0] seen_q;

	logic [7:0]       win_new [MAX_PATTERN_BYTES];
	logic [CNT_W-1:0] seen_inc;
	logic [CNT_W-1:0] len_ext;
	logic             len_ok;
	logic             fits;
	logic             match;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		logic [WIN_IDX_W-1:0] idx;
		logic [LEN_W-1:0]     pos;
		win_new[0] = data_byte;
		for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
			win_new[i] = window_q[i-1];
		end
		seen_inc = (seen_q == SAT_MAX) ? seen_q : seen_q + CNT_W'(1);
		len_ext  = {{(CNT_W-LEN_W){1'b0}}, cfg.length};
		len_ok   = (cfg.length != '0) && (cfg.length <= LEN_W'(MAX_PATTERN_BYTES));
		fits     = seen_inc >= len_ext;
		match    = 1'b1;
		// signature byte k lines up with window slot length-1-k
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
			pos = cfg.length - LEN_W'(1) - LEN_W'(k);
			idx = pos[WIN_IDX_W-1:0];
			if ((LEN_W'(k) < cfg.length) && cfg.mask[k]) begin
				if (win_new[idx] != cfg.pattern[8*k +: 8]) begin
					match = 1'b0;
				end
			end
		end
		push_entry.hit    = len_ok && fits && match;
		push_entry.last   = is_last;
		push_entry.offset = seen_inc - len_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
				window_q[i] <= '0;
			end
		end else if (push) begin
			if (is_last) begin
				// drop the stream state for the next haystack
				seen_q <= '0;
				for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
					window_q[i] <= '0;
				end
			end else begin
				seen_q <= seen_inc;
				for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
					window_q[i] <= win_new[i];
				end
			end
		end
	end

endmodule

`default_nettype wire

[design/mbss_queue.sv]
// ----------------------------------------------------------------------------
// mbss_queue: short queue between front and back end
// Holds classified bytes so that either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module mbss_queue
	import mbss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire mbss_entry_t push_entry,
	output      logic        full,
	input  wire logic        pop,
	output      logic        not_empty,
	output      mbss_entry_t head
);

	mbss_entry_t          store_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign full      = (count_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + Q_CNT_W'(1);
				2'b01:   count_q <= count_q - Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

[design/mbss_back.sv]
// ----------------------------------------------------------------------------
// mbss_back: match accounting and result register
// Counts hits with saturation, keeps the first hit offset and loads one
// result into the output register on each last-marked byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mbss_back
	import mbss_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  not_empty,
	input  wire mbss_entry_t           head,
	output      logic                  pop,
	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      logic [STATUS_W-1:0]   status,
	output      logic [CNT_W-1:0]      hit_total,
	output      logic [CNT_W-1:0]      first_offset
);

	logic [CNT_W-1:0]    hit_count_q;
	logic [CNT_W-1:0]    first_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [CNT_W-1:0]    count_out_q;
	logic [CNT_W-1:0]    offset_out_q;

	logic                can_load;
	logic [CNT_W-1:0]    cnt_next;
	logic [CNT_W-1:0]    first_next;
	logic [STATUS_W-1:0] status_next;

	assign can_load = !out_valid_q || out_ready;
	// a last-marked byte waits until the output register is free
	assign pop      = not_empty && (!head.last || can_load);

	always_comb begin
		cnt_next   = hit_count_q;
		first_next = first_q;
		if (head.hit) begin
			if (hit_count_q == '0) begin
				first_next = head.offset;
			end
			if (hit_count_q != SAT_MAX) begin
				cnt_next = hit_count_q + CNT_W'(1);
			end
		end
		if (cnt_next == '0) begin
			status_next = ST_NOT_FOUND;
		end else if (cnt_next == CNT_W'(1)) begin
			status_next = ST_FOUND;
		end else begin
			status_next = ST_AMBIGUOUS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_count_q <= '0;
			first_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last) begin
					hit_count_q <= '0;
					first_q     <= '0;
				end else begin
					hit_count_q <= cnt_next;
					first_q     <= first_next;
				end
			end
			if (can_load) begin
				out_valid_q <= pop && head.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			status_q     <= status_next;
			count_out_q  <= cnt_next;
			offset_out_q <= (status_next == ST_FOUND) ? first_next : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign hit_total    = count_out_q;
	assign first_offset = offset_out_q;

	a_found_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_FOUND) |-> count_out_q == CNT_W'(1))
		else $error("found status without a single match");
	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ST_FOUND) |-> offset_out_q == '0)
		else $error("offset set without a single match");
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_NOT_FOUND) |-> count_out_q == '0)
		else $error("not found status with matches counted");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.last |=> hit_count_q == '0 && first_q == '0)
		else $error("count not cleared after haystack end");

endmodule

`default_nettype wire

[design/masked_byte_signature_scanner.sv]
// ----------------------------------------------------------------------------
// masked_byte_signature_scanner: wildcard byte signature search over a stream
// Configuration registers, front end compare, queue and back end result.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tdata[7:0] data byte, tlast end of haystack
//  m_axis   | out       | tdata status, hit total, first offset
//  cfg      | in        | cfg_index register, cfg_data value
//
//  One byte per cycle while the queue is not full; shift and masked compare
//  finish in the accept cycle, the entry is written to the queue, and the
//  output register loads when the back end pops the last-marked entry.
//  Reset clears configuration, window, byte count and hit count.
//  A stalled m_axis holds the result; the queue of four bytes keeps s_axis
//  open until it fills behind a waiting last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_signature_scanner
	import mbss_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output      logic                   s_axis_tready,
	input  wire logic [7:0]             s_axis_tdata,  // [7:0] data_byte
	input  wire logic                   s_axis_tlast,
	output      logic                   m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output      logic [OUT_DATA_W-1:0]  m_axis_tdata,  // [1:0] status,
	                                                    // [33:2] hit total,
	                                                    // [65:34] first_offset
	input  wire logic                   cfg_valid,
	output      logic                   cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [CFG_DATA_W-1:0] pat_low_q;
	logic [CFG_DATA_W-1:0] pat_high_q;
	logic [MASK_W-1:0]     mask_q;
	logic [LEN_W-1:0]      length_q;

	mbss_cfg_t             cfg;
	logic                  push;
	mbss_entry_t           push_entry;
	logic                  q_full;
	logic                  pop;
	logic                  q_not_empty;
	mbss_entry_t           head;
	logic [STATUS_W-1:0]   status;
	logic [CNT_W-1:0]      hit_total;
	logic [CNT_W-1:0]      first_offset;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			mask_q     <= '0;
			length_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PATTERN_LOW:    pat_low_q  <= cfg_data;
				CFG_PATTERN_HIGH:   pat_high_q <= cfg_data;
				CFG_PATTERN_MASK:   mask_q     <= cfg_data[MASK_W-1:0];
				CFG_PATTERN_LENGTH: length_q   <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.pattern = {pat_high_q, pat_low_q};
	assign cfg.mask    = mask_q;
	assign cfg.length  = length_q;

	mbss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.data_byte  (s_axis_tdata),
		.is_last    (s_axis_tlast),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	mbss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	mbss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (q_not_empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.status       (status),
		.hit_total    (hit_total),
		.first_offset (first_offset)
	);

	assign m_axis_tdata = {{(OUT_DATA_W-STATUS_W-2*CNT_W){1'b0}},
		first_offset, hit_total, status};

endmodule

`default_nettype wire

[bench/signature_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signature_result_checker: result checking for the signature scanner
// Watches the byte, register and result channels. Keeps its own copy of the
// signature registers and the sliding byte window, predicts the result of
// each haystack, and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module signature_result_checker
	import mbss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
	input  logic                  s_axis_tlast,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [1:0] status, [33:2] hit total,
	                                              // [65:34] first_offset
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           mismatches,
	output int unsigned           outstanding,
	output int unsigned           results_checked,
	output int unsigned           n_not_found,
	output int unsigned           n_found,
	output int unsigned           n_ambiguous
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    count;
		logic [CNT_W-1:0]    offset;
	} scan_result_t;

	logic [PAT_W-1:0]  signature;
	logic [MASK_W-1:0] sig_mask;
	logic [LEN_W-1:0]  sig_len;

	logic [7:0]       byte_hist [MAX_PATTERN_BYTES];
	logic [CNT_W-1:0] bytes_seen;
	logic [CNT_W-1:0] hits;
	logic [CNT_W-1:0] lead_offset;

	scan_result_t pending_results [$];

	initial begin
		mismatches      = 0;
		results_checked = 0;
		n_not_found     = 0;
		n_found         = 0;
		n_ambiguous     = 0;
		outstanding     = 0;
	end

	task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
		input logic [CNT_W-1:0] want);
		$display("@%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic clear_stream();
		foreach (byte_hist[i]) byte_hist[i] = '0;
		bytes_seen  = '0;
		hits        = '0;
		lead_offset = '0;
	endtask

	// shift one haystack byte in, test the window ending at it, close on last
	task automatic scan_byte(input logic [7:0] b, input logic last);
		int           len;
		bit           hit;
		scan_result_t r;
		len = sig_len;
		for (int k = MAX_PATTERN_BYTES - 1; k > 0; k--) byte_hist[k] = byte_hist[k-1];
		byte_hist[0] = b;
		if (bytes_seen != SAT_MAX) bytes_seen++;
		if (len != 0 && len <= MAX_PATTERN_BYTES && bytes_seen >= sig_len) begin
			hit = 1'b1;
			for (int k = 0; k < len; k++) begin
				if (sig_mask[k] && byte_hist[len-1-k] != signature[8*k +: 8]) hit = 1'b0;
			end
			if (hit) begin
				if (hits == '0) lead_offset = bytes_seen - CNT_W'(sig_len);
				if (hits != SAT_MAX) hits++;
			end
		end
		if (last) begin
			r.count = hits;
			if (hits == '0) begin
				r.status = ST_NOT_FOUND;
				r.offset = '0;
				n_not_found++;
			end else if (hits == CNT_W'(1)) begin
				r.status = ST_FOUND;
				r.offset = lead_offset;
				n_found++;
			end else begin
				r.status = ST_AMBIGUOUS;
				r.offset = '0;
				n_ambiguous++;
			end
			pending_results.insert(pending_results.size(), r);
			clear_stream();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_result_t want;
		if (!arst_n) begin
			signature = '0;
			sig_mask  = '0;
			sig_len   = '0;
			clear_stream();
			pending_results.delete();
			outstanding <= 0;
		end else begin
			// compare before pushing: a result never belongs to this cycle's byte
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result status",
						CNT_W'(m_axis_tdata[1:0]), '0);
				end else begin
					want = pending_results.pop_front();
					if (m_axis_tdata[1:0] !== want.status)
						report_mismatch("status", CNT_W'(m_axis_tdata[1:0]),
							CNT_W'(want.status));
					if (m_axis_tdata[33:2] !== want.count)
						report_mismatch("hit total", m_axis_tdata[33:2], want.count);
					if (m_axis_tdata[65:34] !== want.offset)
						report_mismatch("first_offset", m_axis_tdata[65:34], want.offset);
					results_checked++;
				end
			end
			// a byte taken on the same edge as a register write still sees the old value
			if (s_axis_tvalid && s_axis_tready) scan_byte(s_axis_tdata, s_axis_tlast);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PATTERN_LOW:    signature[63:0]   = cfg_data;
					CFG_PATTERN_HIGH:   signature[127:64] = cfg_data;
					CFG_PATTERN_MASK:   sig_mask          = cfg_data[MASK_W-1:0];
					CFG_PATTERN_LENGTH: sig_len           = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

[bench/masked_byte_signature_scanner_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_signature_scanner_tb: stream test of the signature scanner
// Loads signatures through the register channel and streams haystacks of
// directed and random bytes, with random idling on the byte channel and
// random stalls on the result channel; the checker predicts and compares.
// ----------------------------------------------------------------------------
module masked_byte_signature_scanner_tb;
	import mbss_pkg::*;

	localparam int unsigned STALL_LIMIT = 4000;
	localparam int          SETTLE_CYCLES = 10;
	localparam int          PHASE_BYTES = 335;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;
	logic                  s_axis_tlast  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	int unsigned mismatches, outstanding, results_checked;
	int unsigned n_not_found, n_found, n_ambiguous;

	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int unsigned bytes_sent     = 0;
	int unsigned haystacks      = 0;
	int unsigned cfg_writes     = 0;
	int unsigned stuck_cycles   = 0;

	// current signature, mirrored here to shape the haystacks
	logic [PAT_W-1:0]  cur_pattern = '0;
	logic [MASK_W-1:0] cur_mask    = '0;
	logic [LEN_W-1:0]  cur_len     = '0;

	masked_byte_signature_scanner u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	signature_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.n_not_found     (n_not_found),
		.n_found         (n_found),
		.n_ambiguous     (n_ambiguous)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// end the run when no transaction moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STALL_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	function automatic logic [7:0] sig_byte(input int k);
		return cur_pattern[8*k +: 8];
	endfunction

	function automatic logic [7:0] pick_common();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h5A;
			default: return 8'hA5;
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'($urandom_range(0, 255));
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		if (last) haystacks++;
	endtask

	// drop the byte channel, wait for every result, then let the queue drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
	endtask

	task automatic load_signature(input logic [PAT_W-1:0] pat, input logic [MASK_W-1:0] m,
		input logic [LEN_W-1:0] n, input bit junk);
		logic [CFG_DATA_W-1:0] mask_word;
		logic [CFG_DATA_W-1:0] len_word;
		mask_word = junk ? {$urandom, $urandom} : '0;
		len_word  = junk ? {$urandom, $urandom} : '0;
		mask_word[MASK_W-1:0] = m;
		len_word[LEN_W-1:0]   = n;
		write_reg(CFG_PATTERN_LOW, pat[63:0]);
		write_reg(CFG_PATTERN_HIGH, pat[127:64]);
		write_reg(CFG_PATTERN_MASK, mask_word);
		write_reg(CFG_PATTERN_LENGTH, len_word);
		cfg_valid   <= 1'b0;
		cur_pattern = pat;
		cur_mask    = m;
		cur_len     = n;
	endtask

	task automatic random_signature();
		logic [PAT_W-1:0]  p;
		logic [MASK_W-1:0] m;
		logic [LEN_W-1:0]  n;
		bit                wide;
		wide = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < MAX_PATTERN_BYTES; k++)
			p[8*k +: 8] = wide ? 8'($urandom_range(0, 255)) : pick_common();
		case ($urandom_range(0, 9))
			0:       m = '0;
			1:       m = '1;
			default: m = MASK_W'($urandom_range(0, 65535));
		endcase
		case ($urandom_range(0, 19))
			0:       n = '0;
			1:       n = LEN_W'(1);
			2, 3:    n = LEN_W'(MAX_PATTERN_BYTES);
			4:       n = LEN_W'($urandom_range(MAX_PATTERN_BYTES + 1, 31));
			default: n = LEN_W'($urandom_range(1, MAX_PATTERN_BYTES));
		endcase
		load_signature(p, m, n, 1'($urandom_range(0, 1)));
	endtask

	// build a haystack, planting copies of the signature now and then
	task automatic run_haystack(input int n, input int cut);
		logic [7:0] hay [$];
		int         len;
		len = cur_len;
		while (hay.size() < n) begin
			if ($urandom_range(0, 3) == 0 && len != 0 && len <= MAX_PATTERN_BYTES
				&& len <= n - hay.size()) begin
				for (int k = 0; k < len; k++)
					hay.insert(hay.size(),
						cur_mask[k] ? sig_byte(k) : 8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: hay.insert(hay.size(),
						sig_byte($urandom_range(0, MAX_PATTERN_BYTES - 1)));
					5, 6, 7:       hay.insert(hay.size(), pick_common());
					default:       hay.insert(hay.size(), 8'($urandom_range(0, 255)));
				endcase
			end
		end
		for (int i = 0; i < n; i++) begin
			send_byte(hay[i], i == n - 1);
			if (i == cut) begin
				// new signature in the middle of a haystack
				settle();
				random_signature();
				len = cur_len;
			end
		end
	endtask

	initial begin
		int          n;
		int          cut;
		int unsigned phase_start;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: zero length never matches
		settle();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		// one byte signature, mask bits above the length set
		settle();
		load_signature(128'hFF, 16'hFFFF, 5'd1, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		// full length signature over a shorter haystack
		settle();
		load_signature({16{8'hA5}}, 16'hFFFF, 5'd16, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'hA5, 1'b1);
		// length beyond the window, all wildcards
		settle();
		load_signature({{8{8'hFF}}, 64'h0}, 16'h0000, 5'd31, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		// signature replaced between bytes of one haystack
		settle();
		load_signature(128'h2211, 16'h0003, 5'd2, 1'b0);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b0);
		settle();
		load_signature(128'h4433, 16'h0003, 5'd2, 1'b0);
		send_byte(8'h33, 1'b0);
		send_byte(8'h44, 1'b1);
		// valid length with every byte a wildcard
		settle();
		load_signature(128'h0, 16'h0000, 5'd3, 1'b0);
		repeat (3) send_byte(8'h5A, 1'b0);
		send_byte(8'h5A, 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				if ($urandom_range(0, 2) == 0) begin
					settle();
					random_signature();
				end
				case ($urandom_range(0, 19))
					0, 1:    n = $urandom_range(1, 3);
					2:       n = $urandom_range(60, 100);
					default: n = $urandom_range(4, 40);
				endcase
				cut = (n > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(0, n - 2) : -1;
				run_haystack(n, cut);
			end
		end
		settle();

		$display("Scanned %0d bytes in %0d haystacks with %0d register writes over four idle phases",
			bytes_sent, haystacks, cfg_writes);
		$display("Checked %0d results: %0d not found, %0d found, %0d ambiguous",
			results_checked, n_not_found, n_found, n_ambiguous);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
